// ===== rtl/tga_rle_pkg.sv =====
package tga_rle_pkg;

	localparam int PIX_W    = 32;
	localparam int DATA_W   = 64;
	localparam int BCNT_W   = 4;
	localparam int RLEN_W   = 7;

	// Run packets close after this many equal successors (122 pixels in all)
	localparam logic [RLEN_W-1:0] RUN_LIMIT = 7'h79;
	localparam logic [7:0]        RUN_FLAG  = 8'h80;

	// Bytes in one output beat and in one run packet
	localparam logic [BCNT_W-1:0] BEAT_BYTES = 4'd8;
	localparam logic [BCNT_W-1:0] RUN_BYTES  = 4'd5;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                accept;     // latch the incoming pixel
		logic                hold;       // move the incoming pixel into the held slot
		logic                run_load;   // run value takes the held pixel
		logic                wr_en;      // write a pixel into the raw buffer
		logic                wr_sel_in;  // 1: incoming pixel, 0: held pixel
		logic                cap_a;      // capture the first pixel of a beat
		logic                carry_load; // load the carry byte with carry_val
		logic [7:0]          carry_val;
		logic                emit;       // load the output register
		logic                emit_run;   // beat carries the run value
		logic [BCNT_W-1:0]   byte_count;
		logic                packet_end;
		logic                last;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic pix_eq;    // held pixel equals incoming pixel
		logic out_free;  // output register can take a beat this cycle
	} dp_stat_t;

	// Keep the low n bytes of a beat
	function automatic logic [DATA_W-1:0] byte_mask(input logic [BCNT_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int k = 0; k < DATA_W / 8; k++) begin
			if (BCNT_W'(k) < n) begin
				m[8*k +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/tga_rle_dp.sv =====
module tga_rle_dp #(
	parameter int RAW_MAX = 121,
	parameter int ADDR_W  = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [31:0]                s_tdata,
	input  tga_rle_pkg::dp_cmd_t       cmd,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [ADDR_W-1:0]          rd_addr,
	output tga_rle_pkg::dp_stat_t      stat,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [71:0]                m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);
	import tga_rle_pkg::*;

	logic [PIX_W-1:0]  in_pix_q;
	logic [PIX_W-1:0]  held_q;
	logic [PIX_W-1:0]  run_val_q;
	logic [PIX_W-1:0]  pix_a_q;
	logic [PIX_W-1:0]  rdata_q;
	logic [7:0]        carry_q;
	logic [PIX_W-1:0]  raw_mem [RAW_MAX];

	logic [DATA_W-1:0] data_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic              pend_q;
	logic              last_q;
	logic              valid_q;
	logic [DATA_W-1:0] beat;

	// Pixel registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_pix_q <= s_tdata;
		end
		if (cmd.hold) begin
			held_q <= in_pix_q;
		end
		if (cmd.run_load) begin
			run_val_q <= held_q;
		end
		if (cmd.cap_a) begin
			pix_a_q <= rdata_q;
		end
	end

	// Raw pixel buffer, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			raw_mem[wr_addr] <= cmd.wr_sel_in ? in_pix_q : held_q;
		end
		rdata_q <= raw_mem[rd_addr];
	end

	// Carry byte: packet header first, then the alpha byte that spills into the next beat
	always_ff @(posedge clk) begin
		if (cmd.carry_load) begin
			carry_q <= cmd.carry_val;
		end else if (cmd.emit && !cmd.emit_run) begin
			carry_q <= rdata_q[31:24];
		end
	end

	// Assemble a beat and drop the bytes past its count
	always_comb begin
		if (cmd.emit_run) begin
			beat = {24'd0, run_val_q, carry_q};
		end else begin
			beat = {rdata_q[23:0], pix_a_q, carry_q};
		end
		beat = beat & byte_mask(cmd.byte_count);
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			data_q <= beat;
			bcnt_q <= cmd.byte_count;
			pend_q <= cmd.packet_end;
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign stat.pix_eq   = (held_q == in_pix_q);
	assign stat.out_free = !valid_q || m_tready;

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'd0, bcnt_q, data_q};
	assign m_tlast  = pend_q;
	assign m_tuser  = last_q;

endmodule

// ===== rtl/tga_rle_ctrl.sv =====
module tga_rle_ctrl #(
	parameter int RAW_MAX = 121,
	parameter int ADDR_W  = 7,
	parameter int CNT_W   = 7,
	parameter int LEN_W   = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic                       s_tlast,
	input  tga_rle_pkg::dp_stat_t      stat,
	output tga_rle_pkg::dp_cmd_t       cmd,
	output logic [ADDR_W-1:0]          wr_addr,
	output logic [ADDR_W-1:0]          rd_addr
);
	import tga_rle_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_HELD     = 3'd1;
	localparam logic [2:0] ST_ROW      = 3'd2;
	localparam logic [2:0] ST_RD_A     = 3'd3;
	localparam logic [2:0] ST_RD_B     = 3'd4;
	localparam logic [2:0] ST_EMIT_RAW = 3'd5;
	localparam logic [2:0] ST_EMIT_RUN = 3'd6;

	localparam logic [CNT_W-1:0] RAW_FULL = CNT_W'(RAW_MAX);

	logic [2:0]        state_q, state_d;
	logic              held_valid_q, held_valid_d;
	logic              end_q, end_d;
	logic              phase_b_q, phase_b_d;
	logic              last_q, last_d;
	logic [RLEN_W-1:0] run_len_q, run_len_d;
	logic [CNT_W-1:0]  raw_cnt_q, raw_cnt_d;
	logic [CNT_W:0]    idx_q, idx_d;
	logic [LEN_W-1:0]  rem_q, rem_d;

	logic [CNT_W-1:0]  flush_n;
	logic              flush_go;
	logic [CNT_W:0]    idx_next;
	logic              rem_final;

	assign idx_next  = idx_q + (CNT_W+1)'(1);
	assign rem_final = (rem_q <= LEN_W'(8));
	assign wr_addr   = raw_cnt_q[ADDR_W-1:0];

	// Sequencer
	always_comb begin
		state_d      = state_q;
		held_valid_d = held_valid_q;
		end_d        = end_q;
		phase_b_d    = phase_b_q;
		last_d       = last_q;
		run_len_d    = run_len_q;
		raw_cnt_d    = raw_cnt_q;
		idx_d        = idx_q;
		rem_d        = rem_q;
		cmd          = '0;
		s_tready     = 1'b0;
		flush_go     = 1'b0;
		flush_n      = raw_cnt_q;

		// Read the pixel of the second half of a beat unless told otherwise
		if (idx_next < (CNT_W+1)'(RAW_MAX)) begin
			rd_addr = idx_next[ADDR_W-1:0];
		end else begin
			rd_addr = '0;
		end

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					end_d      = s_tlast;
					state_d    = ST_HELD;
				end
			end
			// Settle the held pixel against the new one
			ST_HELD: begin
				held_valid_d = 1'b0;
				phase_b_d    = 1'b0;
				last_d       = !end_q;
				state_d      = ST_ROW;
				if (!held_valid_q) begin
					state_d = ST_ROW;
				end else if (stat.pix_eq && (run_len_q < RUN_LIMIT)) begin
					run_len_d    = run_len_q + RLEN_W'(1);
					cmd.run_load = 1'b1;
					if (raw_cnt_q != '0) begin
						flush_go = 1'b1;
					end
				end else if (run_len_q != '0) begin
					cmd.carry_load = 1'b1;
					cmd.carry_val  = RUN_FLAG | {1'b0, run_len_q};
					run_len_d      = '0;
					state_d        = ST_EMIT_RUN;
				end else begin
					cmd.wr_en = 1'b1;
					if (raw_cnt_q + CNT_W'(1) == RAW_FULL) begin
						flush_go = 1'b1;
						flush_n  = RAW_FULL;
					end else begin
						raw_cnt_d = raw_cnt_q + CNT_W'(1);
					end
				end
			end
			// Close the row, or hold the new pixel
			ST_ROW: begin
				phase_b_d = 1'b1;
				last_d    = 1'b1;
				if (end_q) begin
					if (run_len_q != '0) begin
						cmd.carry_load = 1'b1;
						cmd.carry_val  = RUN_FLAG | {1'b0, run_len_q};
						run_len_d      = '0;
						state_d        = ST_EMIT_RUN;
					end else begin
						cmd.wr_en     = 1'b1;
						cmd.wr_sel_in = 1'b1;
						flush_go      = 1'b1;
						flush_n       = raw_cnt_q + CNT_W'(1);
					end
				end else begin
					cmd.hold     = 1'b1;
					held_valid_d = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RD_A: begin
				if (idx_q < (CNT_W+1)'(RAW_MAX)) begin
					rd_addr = idx_q[ADDR_W-1:0];
				end else begin
					rd_addr = '0;
				end
				state_d = ST_RD_B;
			end
			ST_RD_B: begin
				cmd.cap_a = 1'b1;
				state_d   = ST_EMIT_RAW;
			end
			ST_EMIT_RAW: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.byte_count = rem_final ? rem_q[BCNT_W-1:0] : BEAT_BYTES;
					cmd.packet_end = rem_final;
					cmd.last       = rem_final && last_q;
					if (rem_final) begin
						state_d = phase_b_q ? ST_IDLE : ST_ROW;
					end else begin
						rem_d   = rem_q - LEN_W'(8);
						idx_d   = idx_q + (CNT_W+1)'(2);
						state_d = ST_RD_A;
					end
				end
			end
			ST_EMIT_RUN: begin
				if (stat.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_run   = 1'b1;
					cmd.byte_count = RUN_BYTES;
					cmd.packet_end = 1'b1;
					cmd.last       = last_q;
					state_d        = phase_b_q ? ST_IDLE : ST_ROW;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Start a raw packet: header is the count less one
		if (flush_go) begin
			cmd.carry_load = 1'b1;
			cmd.carry_val  = 8'(flush_n) - 8'd1;
			rem_d          = (LEN_W'(flush_n) << 2) + LEN_W'(1);
			idx_d          = '0;
			raw_cnt_d      = '0;
			state_d        = ST_RD_A;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			held_valid_q <= 1'b0;
			end_q        <= 1'b0;
			phase_b_q    <= 1'b0;
			last_q       <= 1'b0;
			run_len_q    <= '0;
			raw_cnt_q    <= '0;
			idx_q        <= '0;
			rem_q        <= '0;
		end else begin
			state_q      <= state_d;
			held_valid_q <= held_valid_d;
			end_q        <= end_d;
			phase_b_q    <= phase_b_d;
			last_q       <= last_d;
			run_len_q    <= run_len_d;
			raw_cnt_q    <= raw_cnt_d;
			idx_q        <= idx_d;
			rem_q        <= rem_d;
		end
	end

endmodule

// ===== rtl/tga_rle_pixel_encoder.sv =====
// TGA run-length encoder for 32-bit pixels.
// Slave channel: one pixel per beat in s_tdata (blue, green, red, alpha from bit 0),
// s_tlast marks the last pixel of a row. Master channel: packet bytes, up to eight
// per beat, first byte in bits 7:0, byte count in m_tdata[67:64], m_tlast on the
// beat that ends a packet, m_tuser on the final beat caused by one input pixel.
// Each pixel is held one item to compare it with the next; unequal pixels collect
// in a RAW_MAX-entry buffer until their packet closes. Packets never cross a row.
// A pixel that starts no packet passes the held and row states before the next ready.
// A run packet adds one beat. A raw packet of n pixels comes out as ceil((1 + 4n) / 8)
// beats, each built in the states RD_A, RD_B and EMIT_RAW: the buffer has one read port
// and a beat spans two pixels, read one per cycle. The output register lets the next
// beat be built while the current one waits; a stalled m_tready holds the beat and
// pauses the sequencer, and s_tready stays low until the pixel is fully handled.
// Reset clears the held pixel, run and raw counts and the output valid; the raw
// buffer needs no clearing.
module tga_rle_pixel_encoder #(
	parameter int RAW_MAX = 121
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] pixel
	input  logic        s_tlast,   // row_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] data, [67:64] byte_count, [71:68] zero
	output logic        m_tlast,   // packet_end
	output logic        m_tuser    // [0] last
);
	import tga_rle_pkg::*;

	localparam int ADDR_W = (RAW_MAX > 1) ? $clog2(RAW_MAX) : 1;
	localparam int CNT_W  = $clog2(RAW_MAX + 1);
	localparam int LEN_W  = $clog2(4 * RAW_MAX + 10);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	tga_rle_ctrl #(
		.RAW_MAX (RAW_MAX),
		.ADDR_W  (ADDR_W),
		.CNT_W   (CNT_W),
		.LEN_W   (LEN_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	tga_rle_dp #(
		.RAW_MAX (RAW_MAX),
		.ADDR_W  (ADDR_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/tga_rle_chk.sv =====
module tga_rle_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// A stalled beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat withdrawn under stall");

	// Byte count lies in one to eight
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[67:64] != 4'd0) && (m_tdata[67:64] <= 4'd8))
		else $error("byte count out of range");

	// Only the closing beat of a packet may be short
	a_short_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[67:64] != 4'd8) |-> m_tlast)
		else $error("short beat inside a packet");

	// The final beat of a pixel closes a packet
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("pixel finished mid-packet");

endmodule

bind tga_rle_pixel_encoder tga_rle_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ===== bench/tga_rle_pixel_encoder_test.sv =====
`timescale 1ns / 1ps

module tga_rle_pixel_encoder_test;
	import tga_rle_pkg::*;

	localparam int RAW_DEPTH  = 121;
	localparam int IDLE_LIMIT = 2000;
	localparam int ROW_ITEMS  = 380;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [BCNT_W-1:0] byte_count;
		logic              packet_end;
		logic              last;
	} beat_t;

	// Packet predictor and beat checker
	class rle_beat_scoreboard;
		logic [31:0] held_pixel = '0;
		bit          held_valid = 1'b0;
		int unsigned run_len    = 0;
		logic [31:0] run_pixel  = '0;
		logic [31:0] raw_pixels[$];
		logic [7:0]  packet_bytes[$];
		beat_t       pending_beats[$];
		int          fails      = 0;

		task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
			$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
			fails++;
		endtask

		// Split the assembled packet into beats of up to eight bytes
		function void emit_packet();
			int    off;
			int    n;
			beat_t b;
			off = 0;
			while (off < packet_bytes.size()) begin
				n = packet_bytes.size() - off;
				if (n > 8) begin
					n = 8;
				end
				b = '0;
				for (int k = 0; k < n; k++) begin
					b.data[8*k +: 8] = packet_bytes[off + k];
				end
				b.byte_count = BCNT_W'(n);
				b.packet_end = (off + n == packet_bytes.size());
				pending_beats.insert(pending_beats.size(), b);
				off += n;
			end
			packet_bytes.delete();
		endfunction

		// Blue, green, red, alpha
		function void put_pixel(input logic [31:0] p);
			packet_bytes.insert(packet_bytes.size(), p[7:0]);
			packet_bytes.insert(packet_bytes.size(), p[15:8]);
			packet_bytes.insert(packet_bytes.size(), p[23:16]);
			packet_bytes.insert(packet_bytes.size(), p[31:24]);
		endfunction

		function void flush_raw();
			if (raw_pixels.size() == 0) begin
				return;
			end
			packet_bytes.insert(packet_bytes.size(), 8'(raw_pixels.size() - 1));
			foreach (raw_pixels[k]) begin
				put_pixel(raw_pixels[k]);
			end
			emit_packet();
			raw_pixels.delete();
		endfunction

		function void send_run();
			packet_bytes.insert(packet_bytes.size(), RUN_FLAG + 8'(run_len));
			put_pixel(run_pixel);
			emit_packet();
			run_len = 0;
		endfunction

		// Place one pixel into a run or into the raw buffer
		function void absorb(input logic [31:0] p, input bit same_next);
			if (same_next && run_len < RUN_LIMIT) begin
				run_len++;
				run_pixel = p;
				flush_raw();
			end else if (run_len > 0) begin
				send_run();
			end else begin
				raw_pixels.insert(raw_pixels.size(), p);
				if (raw_pixels.size() >= RAW_DEPTH) begin
					flush_raw();
				end
			end
		endfunction

		function void note_pixel(input logic [31:0] p, input logic row_end);
			int    start_cnt;
			beat_t b;
			start_cnt = pending_beats.size();
			if (held_valid) begin
				absorb(held_pixel, held_pixel == p);
				held_valid = 1'b0;
			end
			if (row_end) begin
				absorb(p, 1'b0);
				if (run_len > 0) begin
					send_run();
				end
				flush_raw();
			end else begin
				held_pixel = p;
				held_valid = 1'b1;
			end
			// Mark the final beat caused by this pixel
			if (pending_beats.size() > start_cnt) begin
				b = pending_beats[pending_beats.size() - 1];
				b.last = 1'b1;
				pending_beats[pending_beats.size() - 1] = b;
			end
		endfunction

		task check_beat(input logic [DATA_W-1:0] data, input logic [BCNT_W-1:0] cnt,
				input logic pend, input logic last);
			beat_t want;
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat, data", data, '0);
				return;
			end
			want = pending_beats.pop_front();
			if (data !== want.data) begin
				report_mismatch("data", data, want.data);
			end
			if (cnt !== want.byte_count) begin
				report_mismatch("byte_count", 64'(cnt), 64'(want.byte_count));
			end
			if (pend !== want.packet_end) begin
				report_mismatch("packet_end", 64'(pend), 64'(want.packet_end));
			end
			if (last !== want.last) begin
				report_mismatch("last", 64'(last), 64'(want.last));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	rle_beat_scoreboard sb;
	logic [31:0]        row_pixels[$];
	bit                 calm;

	tga_rle_pixel_encoder #(
		.RAW_MAX(RAW_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one, none in calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	task automatic send_pixel(input logic [31:0] p, input logic row_end);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = p;
		s_tlast  = row_end;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(p, row_end);
	endtask

	// Send the built row, row end on its final pixel
	task automatic play_row(inout int sent);
		foreach (row_pixels[k]) begin
			send_pixel(row_pixels[k], k == row_pixels.size() - 1);
		end
		sent += row_pixels.size();
		row_pixels.delete();
	endtask

	// Hold the sender until every predicted beat has arrived
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_beats.size() != 0) @(posedge clk);
	endtask

	function automatic void add_run(input int n, input logic [31:0] p);
		repeat (n) row_pixels.insert(row_pixels.size(), p);
	endfunction

	// Unequal neighbours
	function automatic void add_raw(input int n);
		logic [31:0] p;
		repeat (n) begin
			do p = $urandom; while (row_pixels.size() > 0 && p == row_pixels[$]);
			row_pixels.insert(row_pixels.size(), p);
		end
	endfunction

	// Small palette, so equal neighbours turn up by chance
	function automatic void add_noise(input int n);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: row_pixels.insert(row_pixels.size(), 32'h0000_0000);
				1: row_pixels.insert(row_pixels.size(), 32'hFFFF_FFFF);
				2: row_pixels.insert(row_pixels.size(), 32'h1234_5678);
				default: row_pixels.insert(row_pixels.size(), 32'h8080_8080);
			endcase
		end
	endfunction

	// Output side: stall at random
	initial begin : sink
		int stall;
		stall    = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Check every accepted beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_beat(m_tdata[63:0], m_tdata[67:64], m_tlast, m_tuser);
		end
	end

	// Abort when neither side moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int row;
		int nseg;
		sb       = new();
		sent     = 0;
		calm     = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single-pixel rows at both extremes
		row_pixels = {32'h0000_0000};
		play_row(sent);
		row_pixels = {32'hFFFF_FFFF};
		play_row(sent);
		// Row end closes a run, then a raw packet
		row_pixels = {32'hA5A5_5A5A, 32'hA5A5_5A5A, 32'hA5A5_5A5A};
		play_row(sent);
		row_pixels = {32'h0000_0001, 32'h0000_0002, 32'h0000_0003};
		play_row(sent);
		// Run start sends the buffered raw pixels first
		row_pixels = {32'h0505_0505, 32'h0606_0606, 32'h0707_0707, 32'h0707_0707,
			32'h0707_0707, 32'h0808_0808};
		play_row(sent);
		row_pixels = {32'hFFFF_FFFF, 32'hFFFF_FFFF};
		play_row(sent);
		row_pixels = {32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
		play_row(sent);
		wait_drained();

		// Random rows, with one long run and one long raw stretch
		row  = 0;
		while (sent < ROW_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if (row == 3) begin
				add_raw($urandom_range(0, 3));
				add_run(122 + $urandom_range(0, 8), $urandom);
				add_raw($urandom_range(1, 3));
			end else if (row == 7) begin
				add_raw(121 + $urandom_range(0, 5));
			end else begin
				nseg = $urandom_range(1, 4);
				repeat (nseg) begin
					case ($urandom_range(0, 2))
						0: add_run($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
							: $urandom_range(2, 8), $urandom);
						1: add_raw($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
							: $urandom_range(1, 8));
						default: add_noise($urandom_range(1, 8));
					endcase
				end
			end
			play_row(sent);
			if (row == 5) begin
				wait_drained();
			end
			row++;
		end

		wait_drained();
		calm = 1'b1;
		repeat (20) @(posedge clk);
		if (sb.fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
